// ===== rtl/spth_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spth_pkg
// Types and constants shared by the swept point triangle hit block.
// ---------------------------------------------------------------------------
package spth_pkg;
	localparam int CoordBits = 20;
	localparam int IndexBits = 10;
	localparam int CountBits = 11;
	localparam int PolyMax   = 1024;
	localparam int MaxSteps  = 64;
	localparam int StepBits  = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;  // holds 0 .. MaxSteps-1
	localparam int UnitLsb   = 40;
	localparam int UnitBits  = $clog2(UnitLsb + 1);
	localparam int DiffBits  = CoordBits + 1;
	localparam int ProdBits  = 2 * DiffBits;
	localparam int LenBits   = 2 * DiffBits + 1;

	localparam logic ActLoad  = 1'b0;
	localparam logic ActQuery = 1'b1;

	typedef logic signed [CoordBits-1:0] coord_t;

	typedef struct packed {
		logic             action;
		logic [IndexBits-1:0] tri_index;
		coord_t v0_x;
		coord_t v0_y;
		coord_t v1_x;
		coord_t v1_y;
		coord_t v2_x;
		coord_t v2_y;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} in_beat_t;

	typedef struct packed {
		logic             hit;
		coord_t           hit_x;
		coord_t           hit_y;
		logic [IndexBits-1:0] hit_index;
		logic             steps_clipped;
	} out_beat_t;

	// triangle vertex record as held in memory
	typedef struct packed {
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
		coord_t cx;
		coord_t cy;
	} tri_t;
endpackage
`default_nettype wire

// ===== rtl/spth_tri_mem.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spth_tri_mem
// Triangle vertex memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module spth_tri_mem (
	input  wire logic                          clk,
	input  wire logic                          wr_en,
	input  wire logic [spth_pkg::IndexBits-1:0] wr_addr,
	input  wire spth_pkg::tri_t                wr_data,
	input  wire logic [spth_pkg::IndexBits-1:0] rd_addr,
	output spth_pkg::tri_t                     rd_data
);
	spth_pkg::tri_t mem [spth_pkg::PolyMax];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ===== rtl/spth_edge_test.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// spth_edge_test
// Two-stage point-in-triangle test: products registered, then sign rule.
// ---------------------------------------------------------------------------
module spth_edge_test (
	input  wire logic           clk,
	input  wire spth_pkg::coord_t px,
	input  wire spth_pkg::coord_t py,
	input  wire spth_pkg::tri_t   tri_in,
	output logic                inside_s2
);
	localparam int DB = spth_pkg::DiffBits;
	localparam int PB = spth_pkg::ProdBits;

	logic signed [PB-1:0] pa_s1 [3];
	logic signed [PB-1:0] pb_s1 [3];
	logic signed [DB-1:0] ex [3];
	logic signed [DB-1:0] ey [3];
	logic signed [DB-1:0] fx [3];
	logic signed [DB-1:0] fy [3];
	logic signed [PB:0]   d [3];
	logic neg, pos;

	always_comb begin
		// edges (a,b), (b,c), (c,a); r is the second vertex
		ex[0] = DB'(px) - DB'(tri_in.bx); ey[0] = DB'(py) - DB'(tri_in.by);
		fx[0] = DB'(tri_in.ax) - DB'(tri_in.bx); fy[0] = DB'(tri_in.ay) - DB'(tri_in.by);
		ex[1] = DB'(px) - DB'(tri_in.cx); ey[1] = DB'(py) - DB'(tri_in.cy);
		fx[1] = DB'(tri_in.bx) - DB'(tri_in.cx); fy[1] = DB'(tri_in.by) - DB'(tri_in.cy);
		ex[2] = DB'(px) - DB'(tri_in.ax); ey[2] = DB'(py) - DB'(tri_in.ay);
		fx[2] = DB'(tri_in.cx) - DB'(tri_in.ax); fy[2] = DB'(tri_in.cy) - DB'(tri_in.ay);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pa_s1[k] <= PB'(ex[k] * fy[k]);
			pb_s1[k] <= PB'(fx[k] * ey[k]);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k] = (PB+1)'(pa_s1[k]) - (PB+1)'(pb_s1[k]);
		end
		neg = d[0][PB] | d[1][PB] | d[2][PB];
		pos = (!d[0][PB] && d[0] != '0) || (!d[1][PB] && d[1] != '0)
			|| (!d[2][PB] && d[2] != '0);
	end

	always_ff @(posedge clk) begin
		inside_s2 <= !(neg && pos);
	end
endmodule
`default_nettype wire

// ===== rtl/swept_point_triangle_hit_top.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// swept_point_triangle_hit_top
// Sampled segment against a table of triangles, first hit reported.
// ---------------------------------------------------------------------------
// A load beat (action 0) writes one triangle into the vertex memory. A query
// beat samples its segment at up to n+1 points, stopping at the first hit, n
// being the least integer with (40 n)^2 >= dx^2 + dy^2, capped at 63 with
// steps_clipped set. Setup forms the squared length and then searches for the
// step count. Each point is then set up and, unless n is 0, goes through a
// bit-serial divider for each axis. The point then streams through poly_count
// triangles (at most 1024), one memory read per cycle, then stops and drains
// a tail through the memory read, product and sign stages. A query's cost is
// set by the single memory read port and the dividers. The result moves to an
// output register, so the next beat is taken while it waits; a finished query
// holds its result until that register is free. Triangles must be loaded
// before they are queried; the memory is not cleared after reset.
// ---------------------------------------------------------------------------
module swept_point_triangle_hit_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [spth_pkg::CountBits-1:0] cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire spth_pkg::in_beat_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output spth_pkg::out_beat_t       out_data
);
	localparam int CB = spth_pkg::CoordBits;
	localparam int DB = spth_pkg::DiffBits;
	localparam int LB = spth_pkg::LenBits;
	localparam int SB = spth_pkg::StepBits;
	localparam int IB = spth_pkg::IndexBits;
	// numerator 2|d|i + n, needs DB+SB+2 bits
	localparam int NB = DB + SB + 2;
	localparam int BB = $clog2(NB);
	localparam int UB = spth_pkg::UnitBits + SB;
	localparam int QB = (2 * UB > LB) ? 2 * UB : LB;

	typedef enum logic [3:0] {
		S_IDLE, S_LEN, S_SRCH, S_DIVX, S_DIVY, S_SCAN, S_DRAIN, S_NEXT, S_OUT
	} state_t;

	state_t state_q;
	logic [spth_pkg::CountBits-1:0] poly_count_q;
	spth_pkg::coord_t sx_q, sy_q, px_q, py_q;
	logic signed [DB-1:0] dx_q, dy_q;
	logic [LB-1:0] len2_q;
	logic [SB-1:0] n_q, i_q, cnt_q;
	logic [2:0] len_ph_q;
	logic clip_q;
	logic [NB-1:0] rem_q, num_q;
	logic [NB-1:0] quo_q;
	logic [BB-1:0] bit_q;
	logic [IB:0] t_q;               // next triangle to read
	logic [IB-1:0] tidx_s1, tidx_s2, tidx_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic [IB:0] count_sat;
	logic [LB-1:0] prod_q;
	logic [DB-1:0] mag_x, mag_y;
	logic [UB-1:0] ucnt;
	logic [2*UB-1:0] lim;
	spth_pkg::tri_t rd_tri;
	spth_pkg::out_beat_t res_q;
	logic inside_s2;
	logic load_go;

	assign count_sat = (poly_count_q > spth_pkg::CountBits'(spth_pkg::PolyMax))
		? (IB+1)'(spth_pkg::PolyMax) : poly_count_q[IB:0];
	assign mag_x = dx_q[DB-1] ? DB'(-dx_q) : DB'(dx_q);
	assign mag_y = dy_q[DB-1] ? DB'(-dy_q) : DB'(dy_q);
	assign in_stall = (state_q != S_IDLE);
	assign load_go = in_valid && !in_stall && (in_data.action == spth_pkg::ActLoad);
	// limit (40 cnt)^2, a constant scale and one squaring on narrow values
	assign ucnt = UB'(spth_pkg::UnitLsb) * UB'(cnt_q);
	assign lim = (2*UB)'(ucnt) * (2*UB)'(ucnt);

	spth_tri_mem u_mem (
		.clk     (clk),
		.wr_en   (load_go),
		.wr_addr (in_data.tri_index),
		.wr_data ({in_data.v0_x, in_data.v0_y, in_data.v1_x,
			in_data.v1_y, in_data.v2_x, in_data.v2_y}),
		.rd_addr (t_q[IB-1:0]),
		.rd_data (rd_tri)
	);

	spth_edge_test u_edge (
		.clk       (clk),
		.px        (px_q),
		.py        (py_q),
		.tri_in    (rd_tri),
		.inside_s2 (inside_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_count_q <= '0;
		end else if (cfg_we) begin
			poly_count_q <= cfg_wdata;
		end
	end

	// scan pipeline: memory read, product stage, sign stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN) && (t_q < count_sat);
			vld_s2 <= vld_s1 && (state_q == S_SCAN || state_q == S_DRAIN);
			vld_s3 <= vld_s2 && (state_q == S_SCAN || state_q == S_DRAIN);
		end
	end
	always_ff @(posedge clk) begin
		tidx_s1 <= t_q[IB-1:0];
		tidx_s2 <= tidx_s1;
		tidx_s3 <= tidx_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			// drop a taken result unless a new one replaces it
			if (out_valid && !out_stall && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_data.action == spth_pkg::ActQuery) begin
						sx_q <= in_data.start_x;
						sy_q <= in_data.start_y;
						dx_q <= DB'(in_data.end_x) - DB'(in_data.start_x);
						dy_q <= DB'(in_data.end_y) - DB'(in_data.start_y);
						len_ph_q <= '0;
						len2_q <= '0;
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					// square x, add, square y, add
					len_ph_q <= len_ph_q + 3'd1;
					case (len_ph_q)
						3'd0: prod_q <= LB'(mag_x * mag_x);
						3'd1: len2_q <= prod_q;
						3'd2: prod_q <= LB'(mag_y * mag_y);
						default: begin
							len2_q <= len2_q + prod_q;
							cnt_q <= '0;
							clip_q <= 1'b1;
							n_q <= SB'(spth_pkg::MaxSteps - 1);
							state_q <= S_SRCH;
						end
					endcase
				end
				S_SRCH: begin
					if (QB'(lim) >= QB'(len2_q)) begin
						n_q <= cnt_q;
						clip_q <= 1'b0;
						i_q <= '0;
						state_q <= S_NEXT;
					end else if (cnt_q == SB'(spth_pkg::MaxSteps - 1)) begin
						i_q <= '0;
						state_q <= S_NEXT;
					end else begin
						cnt_q <= cnt_q + SB'(1);
					end
				end
				S_NEXT: begin
					// set up division of 2|dx| i + n by 2n
					if (n_q == '0) begin
						px_q <= sx_q;
						py_q <= sy_q;
						t_q <= '0;
						state_q <= S_SCAN;
					end else begin
						num_q <= NB'({mag_x, 1'b0}) * NB'(i_q) + NB'(n_q);
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= BB'(NB - 1);
						state_q <= S_DIVX;
					end
				end
				S_DIVX, S_DIVY: begin
					// restoring divide, one quotient bit per cycle
					logic [NB:0] r2;
					logic take;
					logic [NB-1:0] q_fin;
					r2 = {rem_q, num_q[bit_q]};
					take = (r2 >= (NB+1)'({n_q, 1'b0}));
					q_fin = quo_q | NB'(take);
					if (bit_q == '0) begin
						if (state_q == S_DIVX) begin
							px_q <= dx_q[DB-1]
								? CB'(sx_q - CB'(q_fin))
								: CB'(sx_q + CB'(q_fin));
							num_q <= NB'({mag_y, 1'b0}) * NB'(i_q) + NB'(n_q);
							rem_q <= '0;
							quo_q <= '0;
							bit_q <= BB'(NB - 1);
							state_q <= S_DIVY;
						end else begin
							py_q <= dy_q[DB-1]
								? CB'(sy_q - CB'(q_fin))
								: CB'(sy_q + CB'(q_fin));
							t_q <= '0;
							state_q <= S_SCAN;
						end
					end else begin
						if (take) begin
							rem_q <= NB'(r2 - (NB+1)'({n_q, 1'b0}));
							quo_q[bit_q] <= 1'b1;
						end else begin
							rem_q <= NB'(r2);
						end
						bit_q <= bit_q - BB'(1);
					end
				end
				S_SCAN: begin
					// advance reads; on hit, report first hitting triangle
					if (vld_s3 && inside_s2) begin
						res_q <= '{hit: 1'b1, hit_x: px_q, hit_y: py_q,
							hit_index: tidx_s3, steps_clipped: clip_q};
						state_q <= S_OUT;
					end else if (t_q >= count_sat) begin
						state_q <= S_DRAIN;
					end else begin
						t_q <= t_q + (IB+1)'(1);
					end
				end
				S_DRAIN: begin
					if (vld_s3 && inside_s2) begin
						res_q <= '{hit: 1'b1, hit_x: px_q, hit_y: py_q,
							hit_index: tidx_s3, steps_clipped: clip_q};
						state_q <= S_OUT;
					end else if (!vld_s1 && !vld_s2 && !vld_s3) begin
						if (i_q == n_q) begin
							res_q <= '{hit: 1'b0, hit_x: '0, hit_y: '0,
								hit_index: '0, steps_clipped: clip_q};
							state_q <= S_OUT;
						end else begin
							i_q <= i_q + SB'(1);
							state_q <= S_NEXT;
						end
					end
				end
				S_OUT: begin
					// hold the result until the output register is free
					if (!out_valid || !out_stall) begin
						out_data <= res_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	ap_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("input taken while busy");
	ap_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN || state_q == S_OUT))
		else $error("scan beat outside scan");
endmodule
`default_nettype wire

// ===== sim/swept_point_triangle_hit_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// swept_point_triangle_hit_top_test
// Self-checking bench for the sampled segment against triangle table block.
// ---------------------------------------------------------------------------
// An initial block queues load and query beats phase by phase and sets the
// triangle count between phases while the block is idle. A driver offers the
// beats with random idle cycles. Every accepted query is scored by an exact
// integer model of the sampling and the edge sign rule, and a monitor checks
// each result beat against the oldest scored answer.
// ---------------------------------------------------------------------------
module swept_point_triangle_hit_top_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [spth_pkg::CountBits-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	spth_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	spth_pkg::out_beat_t out_data;

	swept_point_triangle_hit_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the triangle table and the count register
	longint tri_x[3*spth_pkg::PolyMax];
	longint tri_y[3*spth_pkg::PolyMax];
	int unsigned tri_count = 0;

	spth_pkg::in_beat_t beats_to_send[$];
	spth_pkg::out_beat_t hits_due[$];
	int errors = 0;
	int results_seen = 0;
	logic in_took = 1'b0;
	bit calm = 0;        // no idling on either side while set
	bit hold_done = 0;
	int hold_left = 0;

	function automatic int cross_sign(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (px - rx) * (qy - ry) - (qx - rx) * (py - ry);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic bit point_in_tri(longint px, longint py, int t);
		int d1, d2, d3;
		d1 = cross_sign(px, py, tri_x[3*t], tri_y[3*t], tri_x[3*t+1], tri_y[3*t+1]);
		d2 = cross_sign(px, py, tri_x[3*t+1], tri_y[3*t+1], tri_x[3*t+2], tri_y[3*t+2]);
		d3 = cross_sign(px, py, tri_x[3*t+2], tri_y[3*t+2], tri_x[3*t], tri_y[3*t]);
		// edge points count as inside: only a mix of both signs is outside
		return !((d1 < 0 || d2 < 0 || d3 < 0) && (d1 > 0 || d2 > 0 || d3 > 0));
	endfunction

	function automatic longint sample_axis(longint s, longint d, longint i, longint n);
		longint q;
		if (n == 0)
			return s;
		q = (2 * (d < 0 ? -d : d) * i + n) / (2 * n);
		return (d < 0) ? s - q : s + q;
	endfunction

	// Apply one accepted beat to the shadow table, score queries
	function automatic void score_beat(spth_pkg::in_beat_t b);
		longint sx, sy, dx, dy, len2, n, px, py;
		int lim;
		spth_pkg::out_beat_t r;
		bit found;
		if (b.action == spth_pkg::ActLoad) begin
			tri_x[3*b.tri_index]   = b.v0_x;
			tri_y[3*b.tri_index]   = b.v0_y;
			tri_x[3*b.tri_index+1] = b.v1_x;
			tri_y[3*b.tri_index+1] = b.v1_y;
			tri_x[3*b.tri_index+2] = b.v2_x;
			tri_y[3*b.tri_index+2] = b.v2_y;
			return;
		end
		sx = b.start_x;
		sy = b.start_y;
		dx = longint'(b.end_x) - sx;
		dy = longint'(b.end_y) - sy;
		len2 = dx * dx + dy * dy;
		r = '0;
		n = 0;
		while (n < spth_pkg::MaxSteps && spth_pkg::UnitLsb * spth_pkg::UnitLsb * n * n < len2)
			n++;
		if (n > spth_pkg::MaxSteps - 1) begin
			n = spth_pkg::MaxSteps - 1;
			r.steps_clipped = 1'b1;
		end
		lim = (tri_count > spth_pkg::PolyMax) ? spth_pkg::PolyMax : tri_count;
		found = 0;
		for (longint i = 0; i <= n && !found; i++) begin
			px = sample_axis(sx, dx, i, n);
			py = sample_axis(sy, dy, i, n);
			for (int t = 0; t < lim && !found; t++) begin
				if (point_in_tri(px, py, t)) begin
					found = 1;
					r.hit = 1'b1;
					r.hit_x = spth_pkg::coord_t'(px);
					r.hit_y = spth_pkg::coord_t'(py);
					r.hit_index = t[spth_pkg::IndexBits-1:0];
				end
			end
		end
		hits_due.push_back(r);
	endfunction

	// Score each beat as the block takes it
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			score_beat(in_data);
	end

	// Driver: hold a stalled beat, otherwise advance or idle at random
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (beats_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
				in_data <= beats_to_send.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall: one long hold-off, else random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen == 10) begin
			hold_done <= 1;
			hold_left <= 600;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(0, 99) < 33);
		end
	end

	// Monitor: compare each result beat with the oldest scored answer
	always @(posedge clk) begin
		spth_pkg::out_beat_t want;
		if (out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (hits_due.size() == 0) begin
				$error("result beat with no query waiting");
				errors++;
			end else begin
				want = hits_due.pop_front();
				if (out_data.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, out_data.hit);
					errors++;
				end
				if (out_data.hit_x !== want.hit_x) begin
					$error("hit_x: expected %0d, got %0d", want.hit_x, out_data.hit_x);
					errors++;
				end
				if (out_data.hit_y !== want.hit_y) begin
					$error("hit_y: expected %0d, got %0d", want.hit_y, out_data.hit_y);
					errors++;
				end
				if (out_data.hit_index !== want.hit_index) begin
					$error("hit_index: expected %0d, got %0d", want.hit_index,
						out_data.hit_index);
					errors++;
				end
				if (out_data.steps_clipped !== want.steps_clipped) begin
					$error("steps_clipped: expected %0d, got %0d", want.steps_clipped,
						out_data.steps_clipped);
					errors++;
				end
			end
		end
	end

	function automatic spth_pkg::in_beat_t load_beat(int slot, int ax, int ay, int bx,
			int by, int cx, int cy);
		spth_pkg::in_beat_t b;
		b = '0;
		b.action = spth_pkg::ActLoad;
		b.tri_index = slot[spth_pkg::IndexBits-1:0];
		b.v0_x = ax; b.v0_y = ay;
		b.v1_x = bx; b.v1_y = by;
		b.v2_x = cx; b.v2_y = cy;
		b.start_x = $urandom; b.start_y = $urandom;  // unused on loads
		b.end_x = $urandom; b.end_y = $urandom;
		return b;
	endfunction

	function automatic spth_pkg::in_beat_t query_beat(int x0, int y0, int x1, int y1);
		spth_pkg::in_beat_t b;
		b = '0;
		b.action = spth_pkg::ActQuery;
		b.tri_index = $urandom;  // unused on queries
		b.v0_x = $urandom; b.v0_y = $urandom;
		b.v1_x = $urandom; b.v1_y = $urandom;
		b.v2_x = $urandom; b.v2_y = $urandom;
		b.start_x = x0; b.start_y = y0;
		b.end_x = x1; b.end_y = y1;
		return b;
	endfunction

	// Triangle near the busy area around the origin
	function automatic spth_pkg::in_beat_t near_tri(int slot);
		int cx, cy;
		cx = $urandom_range(0, 4000) - 2000;
		cy = $urandom_range(0, 4000) - 2000;
		return load_beat(slot, cx + $urandom_range(0, 1600) - 800,
			cy + $urandom_range(0, 1600) - 800, cx + $urandom_range(0, 1600) - 800,
			cy + $urandom_range(0, 1600) - 800, cx + $urandom_range(0, 1600) - 800,
			cy + $urandom_range(0, 1600) - 800);
	endfunction

	task automatic wait_idle();
		while (beats_to_send.size() > 0 || in_valid || hits_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);  // let a trailing load settle
	endtask

	task automatic set_count(int unsigned v);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[spth_pkg::CountBits-1:0];
		tri_count = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sx, sy;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table: misses only, including zero length and a clipped sweep
		set_count(0);
		beats_to_send.push_back(query_beat(524287, 524287, 524287, 524287));
		beats_to_send.push_back(query_beat(-524288, -524288, 524287, 524287));

		// Directed loads: plain, degenerate, clockwise and full-range triangles
		beats_to_send.push_back(load_beat(0, 0, 0, 160, 0, 0, 160));
		beats_to_send.push_back(load_beat(1, 1000, 1000, 1000, 1000, 1000, 1000));
		beats_to_send.push_back(load_beat(2, 2900, 2900, 2900, 3200, 3200, 2900));
		beats_to_send.push_back(load_beat(3, -524288, -524288, 524287, -524288,
			-524288, 524287));
		set_count(4);
		beats_to_send.push_back(query_beat(16, 16, 16, 16));          // interior
		beats_to_send.push_back(query_beat(80, 0, 80, 0));            // on an edge
		beats_to_send.push_back(query_beat(160, 0, 160, 0));          // on a vertex
		beats_to_send.push_back(query_beat(1000, 1000, 1000, 1000));  // degenerate
		beats_to_send.push_back(query_beat(3000, 6000, 3000, 2000));  // clockwise
		beats_to_send.push_back(query_beat(524287, 524287, 524287, 524287));
		beats_to_send.push_back(query_beat(524287, 524287, -524288, -524288));

		// Random phases over sixteen freshly loaded slots
		for (int s = 0; s < 16; s++)
			beats_to_send.push_back(near_tri(s));
		for (int ph = 0; ph < 4; ph++) begin
			set_count(ph == 0 ? 16 : (ph == 1 ? 1 : $urandom_range(1, 16)));
			calm = (ph == 2);
			for (int k = 0; k < 28; k++) begin
				case ($urandom_range(0, 9))
					0: beats_to_send.push_back(load_beat($urandom_range(0, 1023),
						$urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
					1: beats_to_send.push_back(query_beat($urandom, $urandom,
						$urandom, $urandom));
					2, 3: beats_to_send.push_back(near_tri($urandom_range(0, 15)));
					default: begin
						sx = $urandom_range(0, 4000) - 2000;
						sy = $urandom_range(0, 4000) - 2000;
						beats_to_send.push_back(query_beat(sx, sy,
							sx + $urandom_range(0, 4000) - 2000,
							sy + $urandom_range(0, 4000) - 2000));
					end
				endcase
			end
		end
		calm = 0;

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/spth_pkg.sv
rtl/spth_tri_mem.sv
rtl/spth_edge_test.sv
rtl/swept_point_triangle_hit_top.sv
sim/swept_point_triangle_hit_top_test.sv
